// ===== rtl/hrv_pkg.sv =====
// ----------------------------------------------------------------------------
// hrv_pkg: shared types and constants of the HTTP request header validator
// Parse phases, result codes, configuration and result records, text helpers.
// ----------------------------------------------------------------------------
package hrv_pkg;

	localparam logic [2:0] PH_START      = 3'd0;
	localparam logic [2:0] PH_HEADERS    = 3'd1;
	localparam logic [2:0] PH_BODY_LEN   = 3'd2;
	localparam logic [2:0] PH_BODY_CHUNK = 3'd3;
	localparam logic [2:0] PH_DONE       = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_REQUEST = 3'd1;
	localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
	localparam logic [2:0] ST_URI_LONG    = 3'd3;
	localparam logic [2:0] ST_BODY_LARGE  = 3'd4;

	localparam logic [1:0] MT_GET    = 2'd0;
	localparam logic [1:0] MT_POST   = 2'd1;
	localparam logic [1:0] MT_DELETE = 2'd2;
	localparam logic [1:0] MT_OTHER  = 2'd3;

	localparam logic [1:0] BM_NONE    = 2'd0;
	localparam logic [1:0] BM_LENGTH  = 2'd1;
	localparam logic [1:0] BM_CHUNKED = 2'd2;

	localparam logic [1:0] REG_BODY_LIMIT  = 2'd0;
	localparam logic [1:0] REG_URI_LIMIT   = 2'd1;
	localparam logic [1:0] REG_LINE_LIMIT  = 2'd2;
	localparam logic [1:0] REG_BLOCK_LIMIT = 2'd3;

	// line flag bits: request line uses the first pair, header lines the second
	localparam int unsigned LF_BADMETHOD = 0;
	localparam int unsigned LF_URILONG   = 1;
	localparam int unsigned LF_DELIM     = 0;
	localparam int unsigned LF_COLON     = 1;

	// header mask bits
	localparam int unsigned HB_HOST  = 0;
	localparam int unsigned HB_CLEN  = 1;
	localparam int unsigned HB_TENC  = 2;
	localparam int unsigned HB_CTYPE = 3;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_ONE   = 8'h31;

	typedef struct packed {
		logic [31:0] body_limit;
		logic [15:0] uri_limit;
		logic [15:0] line_limit;
		logic [15:0] block_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [2:0]  token_index;
		logic [1:0]  line_flags;
		logic [15:0] uri_count;
		logic [15:0] line_count;
		logic [15:0] block_count;
		logic [3:0]  name_mask;
		logic [3:0]  seen_flags;
		logic        header_fault;
		logic [31:0] length_value;
		logic [31:0] body_count;
		logic [1:0]  term_match;
		logic [31:0] consumed;
		logic [1:0]  method_code;
		logic        minor_version;
	} pst_t;

	typedef struct packed {
		logic [31:0] request_bytes;
		logic [15:0] uri_length;
		logic [31:0] body_length;
		logic [1:0]  body_mode;
		logic        version_minor;
		logic [1:0]  method;
		logic [2:0]  status;
	} res_t;

	// reorder a right-justified string so its first character sits in the low byte
	function automatic logic [63:0] le_text(logic [63:0] s, int unsigned n);
		logic [63:0] w;
		w = '0;
		for (int unsigned i = 0; i < 8; i++) begin
			if (i < n) begin
				w[8*i +: 8] = s[8*(n-1-i) +: 8];
			end
		end
		return w;
	endfunction

	function automatic logic [4:0] hdr_len(logic [1:0] k);
		logic [4:0] n;
		case (k)
			2'd0: n = 5'd4;
			2'd1: n = 5'd14;
			2'd2: n = 5'd17;
			default: n = 5'd12;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] hdr_char(logic [1:0] k, logic [4:0] pos);
		logic [135:0] s;
		int unsigned  n;
		logic [7:0]   c;
		case (k)
			2'd0: s = 136'("host");
			2'd1: s = 136'("content-length");
			2'd2: s = 136'("transfer-encoding");
			default: s = 136'("content-type");
		endcase
		n = 32'(hdr_len(k));
		c = '0;
		if (32'(pos) < n) begin
			c = s[8*(n-1-32'(pos)) +: 8];
		end
		return c;
	endfunction

	function automatic logic [15:0] sat16(logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// ===== rtl/hrv_apb_regs.sv =====
// ----------------------------------------------------------------------------
// hrv_apb_regs: limit registers behind the APB configuration port
// Four limits, written on the access cycle and read back as stored.
// ----------------------------------------------------------------------------
module hrv_apb_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output hrv_pkg::cfg_t cfg
);
	import hrv_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.body_limit  <= 32'd1048576;
			cfg_q.uri_limit   <= 16'd8000;
			cfg_q.line_limit  <= 16'd8000;
			cfg_q.block_limit <= 16'd16000;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_BODY_LIMIT:  cfg_q.body_limit  <= pwdata;
				REG_URI_LIMIT:   cfg_q.uri_limit   <= pwdata[15:0];
				REG_LINE_LIMIT:  cfg_q.line_limit  <= pwdata[15:0];
				REG_BLOCK_LIMIT: cfg_q.block_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BODY_LIMIT:  prdata = cfg_q.body_limit;
			REG_URI_LIMIT:   prdata = {16'd0, cfg_q.uri_limit};
			REG_LINE_LIMIT:  prdata = {16'd0, cfg_q.line_limit};
			REG_BLOCK_LIMIT: prdata = {16'd0, cfg_q.block_limit};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/hrv_parser.sv =====
// ----------------------------------------------------------------------------
// hrv_parser: per-byte parse state and verdict logic
// Holds the request state and advances it by one byte per step.
// ----------------------------------------------------------------------------
module hrv_parser #(
	parameter int unsigned TOKEN_BYTES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    req_byte,
	input  logic          new_request,
	input  hrv_pkg::cfg_t cfg,
	output logic          emit,
	output hrv_pkg::res_t res
);
	import hrv_pkg::*;

	localparam int unsigned TW = TOKEN_BYTES * 8;

	typedef struct packed {
		pst_t            s;
		logic [TW-1:0]   tok;
	} full_t;

	full_t cur_q;
	full_t nxt;
	full_t clear_v;

	function automatic logic tok_is(logic [TW-1:0] tok, logic [15:0] lc,
			logic [63:0] s, int unsigned n);
		logic [63:0] w;
		logic        ok;
		w  = le_text(s, n);
		ok = (lc == 16'(n));
		for (int unsigned i = 0; i < 8; i++) begin
			if (i < n && tok[8*i +: 8] != w[8*i +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic full_t value_char(full_t f, logic [7:0] b);
		full_t       g;
		logic [35:0] p;
		g = f;
		if (g.s.name_mask[HB_CLEN]) begin
			if (b < CH_ZERO || b > CH_NINE) begin
				g.s.header_fault = 1'b1;
			end else begin
				p = ({4'd0, g.s.length_value} << 3) + ({4'd0, g.s.length_value} << 1)
					+ 36'(b - CH_ZERO);
				g.s.length_value = (p[35:32] != 4'd0) ? 32'hFFFF_FFFF : p[31:0];
			end
		end
		return g;
	endfunction

	function automatic full_t start_content(full_t f, logic [7:0] b, cfg_t c);
		full_t       g;
		logic [16:0] n;
		g = f;
		if (b == CH_SP) begin
			if (g.s.token_index == 3'd0) begin
				if (tok_is(g.tok, g.s.line_count, 64'("GET"), 3))
					g.s.method_code = MT_GET;
				else if (tok_is(g.tok, g.s.line_count, 64'("POST"), 4))
					g.s.method_code = MT_POST;
				else if (tok_is(g.tok, g.s.line_count, 64'("DELETE"), 6))
					g.s.method_code = MT_DELETE;
				else if (tok_is(g.tok, g.s.line_count, 64'("HEAD"), 4)
						|| tok_is(g.tok, g.s.line_count, 64'("PUT"), 3)
						|| tok_is(g.tok, g.s.line_count, 64'("OPTIONS"), 7)
						|| tok_is(g.tok, g.s.line_count, 64'("PATCH"), 5))
					g.s.method_code = MT_OTHER;
				else
					g.s.line_flags[LF_BADMETHOD] = 1'b1;
			end
			if (g.s.token_index < 3'd7) g.s.token_index = g.s.token_index + 3'd1;
			g.s.line_count = '0;
		end else begin
			for (int unsigned i = 0; i < TOKEN_BYTES; i++) begin
				if (g.s.line_count == 16'(i)) g.tok[8*i +: 8] = b;
			end
			g.s.line_count = sat16({1'b0, g.s.line_count} + 17'd1);
			if (g.s.token_index == 3'd1) begin
				n = {1'b0, g.s.uri_count} + 17'd1;
				if (n > {1'b0, c.uri_limit}) g.s.line_flags[LF_URILONG] = 1'b1;
				g.s.uri_count = sat16(n);
			end
		end
		return g;
	endfunction

	function automatic full_t header_content(full_t f, logic [7:0] b, cfg_t c);
		full_t       g;
		logic [15:0] pos;
		logic [16:0] n;
		logic [7:0]  lc;
		logic        good;
		logic        done;
		g    = f;
		done = 1'b0;
		pos  = g.s.line_count;
		n = {1'b0, g.s.block_count}
			+ ((g.s.line_count == 16'd0 && g.s.block_count != 16'd0) ? 17'd3 : 17'd1);
		if (n > {1'b0, c.block_limit}) g.s.header_fault = 1'b1;
		g.s.block_count = sat16(n);
		n = {1'b0, g.s.line_count} + 17'd1;
		if (n > {1'b0, c.line_limit}) g.s.header_fault = 1'b1;
		g.s.line_count = sat16(n);

		if (g.s.line_flags[LF_COLON]) begin
			g.s.line_flags[LF_COLON] = 1'b0;
			if (b == CH_SP) begin
				done = 1'b1;
				if (g.s.line_flags[LF_DELIM]) begin
					g.s.header_fault = 1'b1;
				end else begin
					g.s.line_flags[LF_DELIM] = 1'b1;
					for (int k = 0; k < 4; k++) begin
						if (pos != 16'(hdr_len(2'(k))) + 16'd1) g.s.name_mask[k] = 1'b0;
					end
					if (g.s.name_mask[HB_CLEN]) g.s.length_value = '0;
				end
			end else if (g.s.line_flags[LF_DELIM]) begin
				g = value_char(g, CH_COLON);
			end else begin
				g.s.header_fault = 1'b1;
			end
		end
		if (!done) begin
			if (b == CH_COLON) begin
				g.s.line_flags[LF_COLON] = 1'b1;
			end else if (g.s.line_flags[LF_DELIM]) begin
				g = value_char(g, b);
			end else begin
				good = (b >= CH_ZERO && b <= CH_NINE) || (b >= 8'h61 && b <= 8'h7A)
					|| (b >= 8'h41 && b <= 8'h5A) || b == CH_DASH;
				if (!good) g.s.header_fault = 1'b1;
				lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
				for (int k = 0; k < 4; k++) begin
					if (pos >= 16'(hdr_len(2'(k))) || hdr_char(2'(k), pos[4:0]) != lc)
						g.s.name_mask[k] = 1'b0;
				end
			end
		end
		return g;
	endfunction

	function automatic full_t content(full_t f, logic [7:0] b, cfg_t c);
		return (f.s.phase == PH_START) ? start_content(f, b, c) : header_content(f, b, c);
	endfunction

	always_comb begin
		clear_v             = '0;
		clear_v.s.phase     = PH_START;
		clear_v.s.name_mask = 4'hF;
	end

	logic [2:0]  stat;
	logic [1:0]  mode;
	logic [31:0] blen;
	logic        fire_v;
	logic [31:0] clen;
	logic        vok;

	always_comb begin
		nxt    = new_request ? clear_v : cur_q;
		fire_v = 1'b0;
		stat   = ST_OK;
		mode   = BM_NONE;
		blen   = '0;
		clen   = '0;
		vok    = 1'b0;
		if (nxt.s.phase != PH_DONE) begin
			if (nxt.s.consumed != 32'hFFFF_FFFF) nxt.s.consumed = nxt.s.consumed + 32'd1;
			if (nxt.s.phase == PH_BODY_LEN) begin
				nxt.s.body_count = nxt.s.body_count + 32'd1;
				if (nxt.s.body_count == nxt.s.length_value) begin
					fire_v = 1'b1; mode = BM_LENGTH; blen = nxt.s.length_value;
				end
			end else if (nxt.s.phase == PH_BODY_CHUNK) begin
				if (nxt.s.body_count != 32'hFFFF_FFFF)
					nxt.s.body_count = nxt.s.body_count + 32'd1;
				if (req_byte == (nxt.s.term_match[0] ? CH_LF : CH_CR)) begin
					if (nxt.s.term_match == 2'd3) begin
						clen   = nxt.s.body_count - 32'd4;
						fire_v = 1'b1;
						if (clen > cfg.body_limit) begin
							stat = ST_BODY_LARGE;
						end else begin
							mode = BM_CHUNKED; blen = clen;
						end
					end else begin
						nxt.s.term_match = nxt.s.term_match + 2'd1;
					end
				end else begin
					nxt.s.term_match = (req_byte == CH_CR) ? 2'd1 : 2'd0;
				end
				if (!fire_v && nxt.s.body_count > cfg.body_limit) begin
					fire_v = 1'b1; stat = ST_BODY_LARGE;
				end
			end else if (nxt.s.term_match[0] && req_byte == CH_LF) begin
				// line end
				nxt.s.term_match = 2'd0;
				if (nxt.s.phase == PH_START) begin
					vok = tok_is(nxt.tok, nxt.s.line_count, 64'("HTTP/1.0"), 8)
						|| tok_is(nxt.tok, nxt.s.line_count, 64'("HTTP/1.1"), 8);
					if (nxt.s.token_index != 3'd2) begin
						fire_v = 1'b1; stat = ST_BAD_REQUEST;
					end else if (nxt.s.line_flags[LF_BADMETHOD]) begin
						fire_v = 1'b1; stat = ST_BAD_METHOD;
					end else if (nxt.s.line_flags[LF_URILONG]) begin
						fire_v = 1'b1; stat = ST_URI_LONG;
					end else if (!vok) begin
						fire_v = 1'b1; stat = ST_BAD_REQUEST;
					end else begin
						nxt.s.minor_version = (nxt.tok[8*7 +: 8] == CH_ONE);
						nxt.s.phase         = PH_HEADERS;
						nxt.s.line_count    = '0;
						nxt.s.line_flags    = '0;
						nxt.s.name_mask     = 4'hF;
					end
				end else if (nxt.s.line_count == 16'd0) begin
					// blank line: judge the header block
					if (nxt.s.header_fault
							|| (nxt.s.minor_version && !nxt.s.seen_flags[HB_HOST])
							|| (nxt.s.seen_flags[HB_CLEN] && nxt.s.seen_flags[HB_TENC])) begin
						fire_v = 1'b1; stat = ST_BAD_REQUEST;
					end else if (nxt.s.method_code != MT_POST) begin
						fire_v = 1'b1;
					end else if (nxt.s.seen_flags[HB_CLEN]) begin
						if (nxt.s.length_value > cfg.body_limit) begin
							fire_v = 1'b1; stat = ST_BODY_LARGE;
						end else if (nxt.s.length_value == 32'd0) begin
							fire_v = 1'b1; mode = BM_LENGTH;
						end else begin
							nxt.s.phase = PH_BODY_LEN; nxt.s.body_count = '0;
						end
					end else if (nxt.s.seen_flags[HB_TENC]) begin
						nxt.s.phase = PH_BODY_CHUNK; nxt.s.body_count = '0;
						nxt.s.term_match = 2'd0;
					end else begin
						fire_v = 1'b1; stat = ST_BAD_REQUEST;
					end
				end else begin
					if (nxt.s.line_flags[LF_COLON]) begin
						if (nxt.s.line_flags[LF_DELIM]) nxt = value_char(nxt, CH_COLON);
						else nxt.s.header_fault = 1'b1;
					end
					if (!nxt.s.line_flags[LF_DELIM]) begin
						nxt.s.header_fault = 1'b1;
					end else if (nxt.s.name_mask != 4'd0) begin
						if ((nxt.s.seen_flags & nxt.s.name_mask) != 4'd0)
							nxt.s.header_fault = 1'b1;
						nxt.s.seen_flags = nxt.s.seen_flags | nxt.s.name_mask;
					end
					nxt.s.line_count = '0;
					nxt.s.line_flags = '0;
					nxt.s.name_mask  = 4'hF;
				end
			end else begin
				// a lone CR is plain content
				if (nxt.s.term_match[0]) begin
					nxt.s.term_match = 2'd0;
					nxt = content(nxt, CH_CR, cfg);
				end
				if (req_byte == CH_CR) nxt.s.term_match = 2'd1;
				else nxt = content(nxt, req_byte, cfg);
			end
			if (fire_v) nxt.s.phase = PH_DONE;
		end
	end

	always_comb begin
		emit              = fire_v;
		res.status        = stat;
		res.method        = (stat == ST_OK) ? nxt.s.method_code : 2'd0;
		res.version_minor = (stat == ST_OK) ? nxt.s.minor_version : 1'b0;
		res.body_mode     = (stat == ST_OK) ? mode : BM_NONE;
		res.body_length   = (stat == ST_OK) ? blen : 32'd0;
		res.uri_length    = nxt.s.uri_count;
		res.request_bytes = nxt.s.consumed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= clear_v;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

endmodule

// ===== rtl/http_request_header_validator_core.sv =====
// ----------------------------------------------------------------------------
// http_request_header_validator_core: streaming HTTP/1.x request checker
// Takes request bytes on a stream, gives one verdict record per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                   request
//  s_*       in         req_byte (tdata), new_request (tuser)     one byte
//  m_*       out        status .. request_bytes (tdata, 88 bits)  one verdict
//  APB       in/out     body, URI, line and block limits          one register
//
//  A byte is taken into the input register, then parsed from there, once the
//  output register is free or being taken, against the stored request state;
//  a verdict lands in the output register. Sustained rate is one byte per cycle
//  while m_tready keeps the output slot free, set by the per-byte state update.
//  A verdict shows on m_tvalid from the output register, loaded when the deciding byte is parsed.
//  Reset clears parse state, the pipeline valids and loads the default limits.
//  A verdict stalled on m_tready holds the parse step, which holds s_tready.
//
module http_request_header_validator_core #(
	parameter int unsigned TOKEN_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] req_byte
	input  logic        s_tuser,   // [0] new_request
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [2:0] status, [4:3] method, [5] version_minor,
	                               // [7:6] body_mode, [39:8] body_length,
	                               // [55:40] uri_length, [87:56] request_bytes
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hrv_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        new_s1;
	logic        step;
	logic        par_emit;
	res_t        par_res;
	logic        out_valid_q;
	res_t        out_q;

	hrv_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the parser whenever a byte waits and the output slot is free
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			new_s1  <= s_tuser;
		end
	end

	hrv_parser #(
		.TOKEN_BYTES (TOKEN_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.req_byte    (byte_s1),
		.new_request (new_s1),
		.cfg         (cfg),
		.emit        (par_emit),
		.res         (par_res)
	);

	// output register: load a fresh verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && par_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && par_emit) begin
			out_q <= par_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_verdict_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(step && par_emit) |=> (m_tvalid && m_tdata == $past(par_res)))
		else $error("verdict not loaded into output register");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] != ST_OK) |-> (m_tdata[39:3] == 37'd0))
		else $error("error verdict carries nonzero request fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= ST_BODY_LARGE))
		else $error("status code out of range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for http_request_header_validator_core
// Streams whole HTTP requests, one byte per transfer, into the input port. A
// byte-level model of the parser predicts every verdict. Each verdict from the
// output port is checked against the oldest prediction. A short table of
// hand-made requests runs first. Random requests follow under several limit
// settings, with random idle gaps on both ports.
// ----------------------------------------------------------------------------
module testbench;
	import hrv_pkg::*;

	typedef logic [7:0] octet_t;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned COLON_M = 1 << LF_COLON;
	localparam int unsigned DELIM_M = 1 << LF_DELIM;
	localparam int unsigned BADM_M = 1 << LF_BADMETHOD;
	localparam int unsigned URIL_M = 1 << LF_URILONG;
	localparam int unsigned HOST_M = 1 << HB_HOST;
	localparam int unsigned CLEN_M = 1 << HB_CLEN;
	localparam int unsigned TENC_M = 1 << HB_TENC;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	http_request_header_validator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// verdicts predicted but not yet seen on the output port
	res_t        pending_verdicts[$];
	int unsigned faults;
	int unsigned cycles;
	int unsigned verdicts_seen;
	bit          calm;      // no idle gaps on either port while set
	bit          hold_req;  // ask the receiver for one long stall

	// ------------------------------------------------------------------------
	// Parser model: limits, per-request state and the byte step
	// ------------------------------------------------------------------------
	int unsigned lim_body, lim_uri, lim_line, lim_block;
	logic [2:0]  ph;
	octet_t      tok[8];
	int unsigned tok_idx, lflags, uri_cnt, line_cnt, blk_cnt, nmask, seen, hfault;
	int unsigned len_val, body_cnt, term, consumed, mcode, minor;
	string       hdr_names[4] = '{"host", "content-length", "transfer-encoding", "content-type"};

	function automatic void clear_request();
		ph = PH_START;
		foreach (tok[i]) tok[i] = '0;
		tok_idx = 0; lflags = 0; uri_cnt = 0; line_cnt = 0; blk_cnt = 0;
		nmask = 4'hF; seen = 0; hfault = 0; len_val = 0; body_cnt = 0;
		term = 0; consumed = 0; mcode = 0; minor = 0;
	endfunction

	function automatic int unsigned clamp16(int unsigned v);
		return v > 32'hFFFF ? 32'hFFFF : v;
	endfunction

	function automatic bit tok_is(string s);
		int unsigned n;
		n = s.len();
		if (line_cnt != n || n > 8) return 0;
		for (int i = 0; i < n; i++) if (tok[i] != s[i]) return 0;
		return 1;
	endfunction

	// close the request with a verdict; error verdicts carry no method or body info
	function automatic bit settle(logic [2:0] st, logic [1:0] mode, int unsigned blen,
			output res_t v);
		bit ok;
		ok = st == ST_OK;
		v.status = st;
		v.method = ok ? mcode[1:0] : 2'd0;
		v.version_minor = ok ? minor[0] : 1'b0;
		v.body_mode = ok ? mode : BM_NONE;
		v.body_length = ok ? blen : 32'd0;
		v.uri_length = uri_cnt[15:0];
		v.request_bytes = consumed;
		ph = PH_DONE;
		return 1;
	endfunction

	function automatic void start_char(octet_t b);
		int unsigned n;
		if (b == CH_SP) begin
			if (tok_idx == 0) begin
				if (tok_is("GET")) mcode = MT_GET;
				else if (tok_is("POST")) mcode = MT_POST;
				else if (tok_is("DELETE")) mcode = MT_DELETE;
				else if (tok_is("HEAD") || tok_is("PUT") || tok_is("OPTIONS") ||
						tok_is("PATCH")) mcode = MT_OTHER;
				else lflags |= BADM_M;
			end
			if (tok_idx < 7) tok_idx++;
			line_cnt = 0;
			return;
		end
		if (line_cnt < 8) tok[line_cnt] = b;
		line_cnt = clamp16(line_cnt + 1);
		if (tok_idx == 1) begin
			n = uri_cnt + 1;
			if (n > lim_uri) lflags |= URIL_M;
			uri_cnt = clamp16(n);
		end
	endfunction

	function automatic void value_char(octet_t b);
		longint unsigned w;
		if (nmask & CLEN_M) begin
			if (b < CH_ZERO || b > CH_NINE) begin
				hfault = 1;
				return;
			end
			w = longint'(len_val) * 10 + (b - CH_ZERO);
			len_val = w > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : w[31:0];
		end
	endfunction

	function automatic void header_char(octet_t b);
		int unsigned pos, n;
		bit good;
		octet_t lc;
		pos = line_cnt;
		n = blk_cnt + ((line_cnt == 0 && blk_cnt != 0) ? 3 : 1);
		if (n > lim_block) hfault = 1;
		blk_cnt = clamp16(n);
		n = line_cnt + 1;
		if (n > lim_line) hfault = 1;
		line_cnt = clamp16(n);
		// a colon is held until the next byte tells whether it is the ": " delimiter
		if (lflags & COLON_M) begin
			lflags &= ~COLON_M;
			if (b == CH_SP) begin
				if (lflags & DELIM_M) begin
					hfault = 1;
					return;
				end
				lflags |= DELIM_M;
				for (int k = 0; k < 4; k++)
					if (pos - 1 != hdr_names[k].len()) nmask &= ~(1 << k);
				if (nmask & CLEN_M) len_val = 0;
				return;
			end
			if (lflags & DELIM_M) value_char(CH_COLON);
			else hfault = 1;
		end
		if (b == CH_COLON) begin
			lflags |= COLON_M;
			return;
		end
		if (lflags & DELIM_M) begin
			value_char(b);
			return;
		end
		good = (b >= CH_ZERO && b <= CH_NINE) || (b >= "a" && b <= "z") ||
			(b >= "A" && b <= "Z") || b == CH_DASH;
		if (!good) hfault = 1;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		for (int k = 0; k < 4; k++)
			if (pos >= hdr_names[k].len() || hdr_names[k][pos] != lc) nmask &= ~(1 << k);
	endfunction

	function automatic void line_char(octet_t b);
		if (ph == PH_START) start_char(b);
		else header_char(b);
	endfunction

	function automatic bit judge_block(output res_t v);
		if (hfault) return settle(ST_BAD_REQUEST, BM_NONE, 0, v);
		if (minor != 0 && !(seen & HOST_M)) return settle(ST_BAD_REQUEST, BM_NONE, 0, v);
		if ((seen & CLEN_M) && (seen & TENC_M)) return settle(ST_BAD_REQUEST, BM_NONE, 0, v);
		if (mcode != MT_POST) return settle(ST_OK, BM_NONE, 0, v);
		if (seen & CLEN_M) begin
			if (len_val > lim_body) return settle(ST_BODY_LARGE, BM_NONE, 0, v);
			if (len_val == 0) return settle(ST_OK, BM_LENGTH, 0, v);
			ph = PH_BODY_LEN;
			body_cnt = 0;
			return 0;
		end
		if (seen & TENC_M) begin
			ph = PH_BODY_CHUNK;
			body_cnt = 0;
			term = 0;
			return 0;
		end
		return settle(ST_BAD_REQUEST, BM_NONE, 0, v);
	endfunction

	function automatic bit end_of_line(output res_t v);
		bit vok;
		if (ph == PH_START) begin
			vok = tok_is("HTTP/1.0") || tok_is("HTTP/1.1");
			if (tok_idx != 2) return settle(ST_BAD_REQUEST, BM_NONE, 0, v);
			if (lflags & BADM_M) return settle(ST_BAD_METHOD, BM_NONE, 0, v);
			if (lflags & URIL_M) return settle(ST_URI_LONG, BM_NONE, 0, v);
			if (!vok) return settle(ST_BAD_REQUEST, BM_NONE, 0, v);
			minor = tok[7] == CH_ONE;
			ph = PH_HEADERS;
			line_cnt = 0; lflags = 0; nmask = 4'hF;
			return 0;
		end
		if (line_cnt == 0) return judge_block(v);
		if (lflags & COLON_M) begin
			if (lflags & DELIM_M) value_char(CH_COLON);
			else hfault = 1;
		end
		if (!(lflags & DELIM_M)) begin
			hfault = 1;
		end else if (nmask != 0) begin
			if (seen & nmask) hfault = 1;
			seen |= nmask;
		end
		line_cnt = 0; lflags = 0; nmask = 4'hF;
		return 0;
	endfunction

	// advance the model by one request byte; returns 1 when a verdict is due
	function automatic bit parse_byte(octet_t b, bit fresh, output res_t v);
		int unsigned m;
		octet_t seq[4];
		seq = '{CH_CR, CH_LF, CH_CR, CH_LF};
		if (fresh) clear_request();
		if (ph == PH_DONE) return 0;
		if (consumed != 32'hFFFF_FFFF) consumed++;
		if (ph == PH_BODY_LEN) begin
			body_cnt++;
			if (body_cnt == len_val) return settle(ST_OK, BM_LENGTH, len_val, v);
			return 0;
		end
		if (ph == PH_BODY_CHUNK) begin
			if (body_cnt != 32'hFFFF_FFFF) body_cnt++;
			m = term & 3;
			if (b == seq[m]) begin
				if (m == 3) begin
					if (body_cnt - 4 > lim_body) return settle(ST_BODY_LARGE, BM_NONE, 0, v);
					return settle(ST_OK, BM_CHUNKED, body_cnt - 4, v);
				end
				term = m + 1;
			end else begin
				term = (b == CH_CR) ? 1 : 0;
			end
			if (body_cnt > lim_body) return settle(ST_BODY_LARGE, BM_NONE, 0, v);
			return 0;
		end
		// a CR counts as a line end only when LF follows it
		if (term & 1) begin
			term = 0;
			if (b == CH_LF) return end_of_line(v);
			line_char(CH_CR);
		end
		if (b == CH_CR) term = 1;
		else line_char(b);
		return 0;
	endfunction

	// ------------------------------------------------------------------------
	// Clock, reset and watchdog
	// ------------------------------------------------------------------------
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("http_request_header_validator_core: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Output side: random stalls, then check each verdict against the oldest
	// prediction
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall;
		res_t got, want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (hold_req) begin
				stall = LONG_HOLD;
				hold_req = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				$error("verdict with none expected: %h", m_tdata);
				faults++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					faults++;
				end
				if (got.method !== want.method) begin
					$error("method: expected %0d, got %0d", want.method, got.method);
					faults++;
				end
				if (got.version_minor !== want.version_minor) begin
					$error("version_minor: expected %0d, got %0d", want.version_minor,
						got.version_minor);
					faults++;
				end
				if (got.body_mode !== want.body_mode) begin
					$error("body_mode: expected %0d, got %0d", want.body_mode, got.body_mode);
					faults++;
				end
				if (got.body_length !== want.body_length) begin
					$error("body_length: expected %0d, got %0d", want.body_length,
						got.body_length);
					faults++;
				end
				if (got.uri_length !== want.uri_length) begin
					$error("uri_length: expected %0d, got %0d", want.uri_length, got.uri_length);
					faults++;
				end
				if (got.request_bytes !== want.request_bytes) begin
					$error("request_bytes: expected %0d, got %0d", want.request_bytes,
						got.request_bytes);
					faults++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// offer one byte after a random gap; at acceptance, step the model and
	// queue any verdict (chk forces the status typed in the table)
	task automatic offer_byte(octet_t b, bit fresh, bit chk, logic [2:0] st);
		int unsigned gap;
		res_t v;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= fresh;
		do @(posedge clk); while (!s_tready);
		if (parse_byte(b, fresh, v)) begin
			if (chk) v.status = st;
			pending_verdicts = {pending_verdicts, v};
		end
	endtask

	task automatic send_request(octet_t q[$], bit chk, logic [2:0] st);
		foreach (q[i]) offer_byte(q[i], i == 0, chk, st);
	endtask

	// drop valid, then wait until every verdict is in and the pipe is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [1:0] idx, int unsigned value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BODY_LIMIT: lim_body = value;
			REG_URI_LIMIT: lim_uri = value & 32'hFFFF;
			REG_LINE_LIMIT: lim_line = value & 32'hFFFF;
			default: lim_block = value & 32'hFFFF;
		endcase
	endtask

	function automatic void add_text(ref octet_t q[$], input string s);
		for (int i = 0; i < s.len(); i++) q = {q, octet_t'(s[i])};
	endfunction

	function automatic string mixed_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
		return r;
	endfunction

	// build one random request: mostly well formed, some noise and breakage
	function automatic void compose_request(ref octet_t q[$]);
		string methods[10] = '{"GET", "POST", "DELETE", "HEAD", "PUT", "OPTIONS", "PATCH",
			"get", "POS", "BREW"};
		string versions[4] = '{"HTTP/1.1", "HTTP/1.0", "HTTP/1.2", "HTTP/1.1x"};
		string uri_chars = "abcxyz0189/-._~?=%";
		int unsigned mi, n, kind, clen;
		bit post, use_cl, use_te;
		q.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 24);
			repeat (n) q = {q, octet_t'($urandom_range(0, 255))};
			return;
		end
		mi = $urandom_range(0, 2) == 0 ? 1 : ($urandom_range(0, 5) == 0 ?
			$urandom_range(7, 9) : $urandom_range(0, 6));
		post = mi == 1;
		add_text(q, methods[mi]);
		add_text(q, " /");
		n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 6);
		repeat (n) q = {q, octet_t'(uri_chars[$urandom_range(0, uri_chars.len() - 1)])};
		if ($urandom_range(0, 19) == 0) add_text(q, " ");
		if ($urandom_range(0, 19) != 0) begin
			add_text(q, " ");
			add_text(q, versions[$urandom_range(0, 9) == 0 ? $urandom_range(2, 3) :
				$urandom_range(0, 1)]);
		end
		add_text(q, "\r\n");
		if ($urandom_range(0, 9) != 0) add_text(q, {mixed_case("host"), ": example.org\r\n"});
		use_cl = post ? $urandom_range(0, 1) : $urandom_range(0, 5) == 0;
		use_te = post ? (!use_cl || $urandom_range(0, 9) == 0) : $urandom_range(0, 5) == 0;
		if (post && $urandom_range(0, 9) == 0) begin
			use_cl = 0;
			use_te = 0;
		end
		clen = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 14);
		if (use_cl) add_text(q, {mixed_case("content-length"), ": ",
			$sformatf("%0d", clen),
			($urandom_range(0, 14) == 0) ? string'("x") : string'(""), "\r\n"});
		if (use_te) add_text(q, {mixed_case("transfer-encoding"), ": chunked\r\n"});
		n = $urandom_range(0, 3);
		repeat (n) begin
			kind = $urandom_range(0, 7);
			case (kind)
				0: add_text(q, "Content-Type: text/plain\r\n");
				1: add_text(q, "X-Trace-9: a:b: c\r\n");
				2: add_text(q, "Bad Name: v\r\n");
				3: add_text(q, "nocolon\r\n");
				4: add_text(q, "Host: dup\r\n");
				5: add_text(q, "A:b\r\n");
				6: add_text(q, "Accept: */*\r\n");
				default: add_text(q, "User-Agent: probe-1.0 lab\r\n");
			endcase
		end
		add_text(q, "\r\n");
		if (use_cl) repeat (clen) q = {q, octet_t'($urandom_range(0, 255))};
		if (use_te) begin
			n = $urandom_range(0, 12);
			repeat (n) q = {q, octet_t'($urandom_range(0, 255))};
			add_text(q, $urandom_range(0, 1) ? string'("\r\n\r\n") :
				string'("3\r\nabc\r\n0\r\n\r\n"));
		end
		if ($urandom_range(0, 4) == 0) add_text(q, "zz");
		if ($urandom_range(0, 19) == 0)
			q[$urandom_range(0, q.size() - 1)] = octet_t'($urandom_range(0, 255));
	endfunction

	typedef struct {
		string      text;
		bit         chk;
		logic [2:0] st;
	} req_row_t;

	typedef struct {
		int unsigned body, uri, line, block;
	} limits_t;

	initial begin
		req_row_t rows[$];
		limits_t settings[5];
		octet_t q[$];
		int unsigned bytes_sent, target_bytes, target_verdicts;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		faults = 0;
		cycles = 0;
		verdicts_seen = 0;
		calm = 0;
		hold_req = 0;
		clear_request();
		lim_body = 1048576; lim_uri = 8000; lim_line = 8000; lim_block = 16000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-made requests under the reset limits
		rows = '{
			'{"GET / HTTP/1.0\r\n\r\nxyz", 1, ST_OK},
			'{"GET / HTTP/1.1\r\n\r\n", 1, ST_BAD_REQUEST},
			'{"FOO / HTTP/1.1\r\n", 1, ST_BAD_METHOD},
			'{"get / HTTP/1.0\r\n", 1, ST_BAD_METHOD},
			'{"GET /  HTTP/1.1\r\n", 1, ST_BAD_REQUEST},
			'{"GET / HTTP/2.0\r\n", 1, ST_BAD_REQUEST},
			'{"POST /a HTTP/1.1\r\nHost: x\r\nContent-Length: 3\r\n\r\nabc", 0, ST_OK},
			'{"PUT /x HTTP/1.1\r\nhost: h\r\nTransfer-Encoding: chunked\r\n\r\n", 0, ST_OK},
			'{"POST / HTTP/1.0\r\nTransfer-Encoding: chunked\r\n\r\n5\r\nhello\r\n0\r\n\r\n",
				0, ST_OK},
			'{"POST / HTTP/1.0\r\nContent-Length: 0\r\n\r\n", 0, ST_OK},
			'{"POST / HTTP/1.0\r\n\r\n", 1, ST_BAD_REQUEST},
			'{"GET / HTTP/1.0\r\nHost: a\r\nhost: b\r\n\r\n", 1, ST_BAD_REQUEST},
			'{"GET / HTTP/1.0\r\nContent-Length: 1\r\nTransfer-Encoding: x\r\n\r\n", 1,
				ST_BAD_REQUEST},
			'{"POST / HTTP/1.0\r\nContent-Length: 1x\r\n\r\n", 1, ST_BAD_REQUEST},
			'{"GET / HTTP/1.0\r\n: \r\n\r\n", 0, ST_OK},
			'{"GET / HTTP/1.0\r\nX\rY: v\r\n\r\n", 1, ST_BAD_REQUEST},
			'{"POST / HTTP/1.0\r\nContent-Length: 99999999999\r\n\r\n", 1, ST_BODY_LARGE},
			'{"HEAD / HTTP/1.0\r\nA: b:c\r\n\r\n", 0, ST_OK},
			'{"DELETE /d HTTP/1.1\r\nHost: z\r\n\r\n", 0, ST_OK},
			'{"OPTIONS * HTTP/1.0\r\n\r\n", 0, ST_OK},
			'{"PATCH /p HTTP/1.0\r\nGood: x\r\n\r\n", 0, ST_OK}
		};
		foreach (rows[r]) begin
			q.delete();
			add_text(q, rows[r].text);
			send_request(q, rows[r].chk, rows[r].st);
		end
		drain();

		// random requests under each limit setting; tight and extreme ones included
		settings = '{
			'{1048576, 8000, 8000, 16000},
			'{10, 4, 16, 40},
			'{0, 0, 0, 0},
			'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			'{$urandom_range(0, 30), $urandom_range(0, 12), $urandom_range(5, 40),
				$urandom_range(10, 120)}
		};
		bytes_sent = 0;
		foreach (settings[p]) begin
			write_limit(REG_BODY_LIMIT, settings[p].body);
			write_limit(REG_URI_LIMIT, settings[p].uri);
			write_limit(REG_LINE_LIMIT, settings[p].line);
			write_limit(REG_BLOCK_LIMIT, settings[p].block);
			target_bytes = (p + 1) * 60;
			target_verdicts = verdicts_seen + pending_verdicts.size() + 3;
			// one long receiver stall while the sender keeps pushing
			if (p == 1) hold_req = 1;
			while (bytes_sent < target_bytes ||
					verdicts_seen + pending_verdicts.size() < target_verdicts) begin
				calm = $urandom_range(0, 4) == 0;
				compose_request(q);
				send_request(q, 0, ST_OK);
				bytes_sent += q.size();
			end
			calm = 0;
			drain();
		end

		if (faults == 0) begin
			$display("http_request_header_validator_core: match");
		end else begin
			$display("http_request_header_validator_core: mismatch");
		end
		$finish;
	end

endmodule
